@@ design/fpn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpn_pkg
// Shared widths, action codes and divider handshake types for the frame peak
// normalizer.
// ----------------------------------------------------------------------------
package fpn_pkg;

	localparam int SAMPLE_W       = 24;
	localparam int FRAC_BITS      = 20;
	localparam int THR_W          = 23;
	localparam int FRAME_W        = 4;
	localparam int INDEX_W        = 11;
	localparam int DEF_FRAME_SIZE = 2048;
	localparam int DEF_NUM_FRAMES = 16;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_READ = 1'b1;

	typedef struct packed {
		logic                start;
		logic                neg;
		logic [SAMPLE_W-1:0] mag;
		logic [SAMPLE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [SAMPLE_W-1:0] value;
	} div_rsp_t;

endpackage

@@ design/fpn_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpn_store
// Sample memory for all frames: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fpn_store import fpn_pkg::*; #(
	parameter int DEPTH = DEF_FRAME_SIZE * DEF_NUM_FRAMES,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  logic [SAMPLE_W-1:0] wdata,
	input  logic                re,
	input  logic [AW-1:0]       raddr,
	output logic [SAMPLE_W-1:0] rdata
);

	logic [SAMPLE_W-1:0] mem [DEPTH];
	logic [SAMPLE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/fpn_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpn_div
// Bit-serial restoring divider: (mag << 20) / divisor, one quotient bit per
// cycle, then saturation and sign in a final step.
// ----------------------------------------------------------------------------
module fpn_div import fpn_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int                  CW       = $clog2(SAMPLE_W);
	localparam logic [CW-1:0]       CNT_LAST = CW'(SAMPLE_W - 1);
	localparam int                  LOW_W    = SAMPLE_W - FRAC_BITS;
	localparam logic [SAMPLE_W-1:0] POS_MAX  = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic [SAMPLE_W-1:0] NEG_MAX  = {1'b1, {(SAMPLE_W-1){1'b0}}};

	logic            busy_q;
	logic            fin_q;
	logic            done_q;
	logic [CW-1:0]   cnt_q;
	logic [SAMPLE_W:0]   rem_q;
	logic [SAMPLE_W-1:0] dsr_q;
	logic [SAMPLE_W-1:0] bits_q;
	logic [SAMPLE_W-1:0] quo_q;
	logic            neg_q;
	logic [SAMPLE_W-1:0] value_q;

	logic [SAMPLE_W:0]   trial;
	logic [SAMPLE_W:0]   diff;
	logic                ge;
	logic                ovf;
	logic [SAMPLE_W-1:0] sat;

	// quotient of 2^24 or more: mag >= divisor * 16
	assign ovf   = {{LOW_W{1'b0}}, req.mag} >= {req.divisor, {LOW_W{1'b0}}};
	assign trial = {rem_q[SAMPLE_W-1:0], bits_q[SAMPLE_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_comb begin
		if (neg_q) begin
			sat = (quo_q > NEG_MAX) ? NEG_MAX : quo_q;
			sat = SAMPLE_W'(0) - sat;
		end else begin
			sat = (quo_q > POS_MAX) ? POS_MAX : quo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			fin_q  <= 1'b0;
			if (req.start) begin
				busy_q <= !ovf;
				fin_q  <= ovf;
				cnt_q  <= CNT_LAST;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q  <= req.neg;
			dsr_q  <= req.divisor;
			rem_q  <= {{(LOW_W+1){1'b0}}, req.mag[SAMPLE_W-1:LOW_W]};
			bits_q <= {req.mag[LOW_W-1:0], {FRAC_BITS{1'b0}}};
			quo_q  <= ovf ? '1 : '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff : trial;
			bits_q <= {bits_q[SAMPLE_W-2:0], 1'b0};
			quo_q  <= {quo_q[SAMPLE_W-2:0], ge};
		end
		if (fin_q) begin
			value_q <= sat;
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = value_q;

endmodule

@@ design/frame_peak_normalizer_core.sv @@
`timescale 1ns / 1ps
// Load: written on accept, next beat accepted in the following cycle. Read,
// scaled: the sample is read in ST_RD, then the serial divider takes one quotient
// bit per cycle in ST_DIV (skipped when the quotient saturates), then ST_DONE.
// Unscaled read: ST_RD, then ST_DONE. One item in flight; a finished result waits
// in the output register while the next beat is taken. Reset clears frame peaks,
// threshold and control; sample memory is not cleared.
// ----------------------------------------------------------------------------
// frame_peak_normalizer_core
// Wavetable frame bank with per-frame running peak and peak-normalized reads.
// ----------------------------------------------------------------------------
module frame_peak_normalizer_core import fpn_pkg::*; #(
	parameter int FRAME_SIZE = DEF_FRAME_SIZE,
	parameter int NUM_FRAMES = DEF_NUM_FRAMES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [THR_W-1:0]    cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                action,
	input  logic [FRAME_W-1:0]  frame,
	input  logic [INDEX_W-1:0]  index,
	input  logic [SAMPLE_W-1:0] sample,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SAMPLE_W-1:0] value,
	output logic [SAMPLE_W-1:0] peak,
	output logic                scaled
);

	localparam int DEPTH = NUM_FRAMES * FRAME_SIZE;
	localparam int AW    = $clog2(DEPTH);
	localparam int FW    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

	typedef enum logic [1:0] {ST_IDLE, ST_RD, ST_DIV, ST_DONE} state_t;

	state_t              state_q;
	logic [THR_W-1:0]    thr_q;
	logic [SAMPLE_W-1:0] peak_q [NUM_FRAMES];
	logic [SAMPLE_W-1:0] cap_peak_q;
	logic                cap_scl_q;
	logic [SAMPLE_W-1:0] res_val_q;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] value_q;
	logic [SAMPLE_W-1:0] peak_out_q;
	logic                scaled_q;

	logic [8:0]          frame_ext;
	logic [FW-1:0]       fi;
	logic                in_range;
	logic                acc;
	logic [AW-1:0]       addr;
	logic [SAMPLE_W-1:0] mag;
	logic [SAMPLE_W-1:0] cur_peak;
	logic [SAMPLE_W-1:0] rd_data;
	logic [SAMPLE_W-1:0] rd_mag;
	logic                out_free;
	div_req_t            div_req;
	div_rsp_t            div_rsp;

	assign frame_ext = {5'b0, frame};
	assign fi        = frame_ext[FW-1:0];
	assign in_range  = (frame_ext < 9'(NUM_FRAMES)) && ({3'b0, index} < 14'(FRAME_SIZE));
	assign in_ready  = (state_q == ST_IDLE);
	assign acc       = in_valid && in_ready && in_range;
	assign addr      = AW'(32'(frame_ext) * FRAME_SIZE + 32'(index));
	assign mag       = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
	assign cur_peak  = peak_q[fi];
	assign rd_mag    = rd_data[SAMPLE_W-1] ? (~rd_data + 1'b1) : rd_data;
	assign out_free  = !out_valid_q || out_ready;

	fpn_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
		.clk   (clk),
		.we    (acc && (action == ACT_LOAD)),
		.waddr (addr),
		.wdata (sample),
		.re    (acc && (action == ACT_READ)),
		.raddr (addr),
		.rdata (rd_data)
	);

	assign div_req.start   = (state_q == ST_RD) && cap_scl_q;
	assign div_req.neg     = rd_data[SAMPLE_W-1];
	assign div_req.mag     = rd_mag;
	assign div_req.divisor = cap_peak_q;

	fpn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			thr_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_FRAMES; i++) begin
				peak_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (action == ACT_LOAD) begin
							if (index == '0 || mag > cur_peak) begin
								peak_q[fi] <= mag;
							end
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= cap_scl_q ? ST_DIV : ST_DONE;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc && (action == ACT_READ)) begin
			cap_peak_q <= cur_peak;
			cap_scl_q  <= cur_peak > {1'b0, thr_q};
		end
		if (state_q == ST_RD) begin
			res_val_q <= rd_data;
		end else if (state_q == ST_DIV && div_rsp.done) begin
			res_val_q <= div_rsp.value;
		end
		if (state_q == ST_DONE && out_free) begin
			value_q    <= res_val_q;
			peak_out_q <= cap_peak_q;
			scaled_q   <= cap_scl_q;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign peak      = peak_out_q;
	assign scaled    = scaled_q;

endmodule

@@ design/fpn_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpn_checker
// Port-level checks for the frame peak normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module fpn_checker import fpn_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                cfg_we,
	input logic [THR_W-1:0]    cfg_wdata,
	input logic                out_valid,
	input logic                out_ready,
	input logic [SAMPLE_W-1:0] value,
	input logic [SAMPLE_W-1:0] peak,
	input logic                scaled
);

	localparam logic [SAMPLE_W-1:0] PEAK_MAX = {1'b1, {(SAMPLE_W-1){1'b0}}};

	logic [THR_W-1:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value) && $stable(peak)
			&& $stable(scaled))
		else $error("result beat changed while stalled");

	a_scaled_above: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && scaled |-> peak > {1'b0, thr_q})
		else $error("scaled result with peak at or below threshold");

	a_raw_below: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !scaled |-> peak <= {1'b0, thr_q})
		else $error("raw result with peak above threshold");

	a_peak_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> peak <= PEAK_MAX)
		else $error("peak out of range");

endmodule

bind frame_peak_normalizer_core fpn_checker u_fpn_checker (.*);

@@ verif/frame_peak_normalizer_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_peak_normalizer_core_tb
// Self-checking bench for the frame peak normalizer. A directed table comes
// first, with fixed expectations where they are obvious. Random load/read
// traffic follows over several silence thresholds. Reads target only written
// entries. Reads with no fixed result are scored against an in-bench model
// of the normalizer; input pacing is bursty and output backpressure random.
// ----------------------------------------------------------------------------
module frame_peak_normalizer_core_tb;
	import fpn_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int SETTLE_CYC  = 50;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 222;
	localparam int DIR_ROWS    = 23;
	localparam int MEM_DEPTH   = DEF_NUM_FRAMES * DEF_FRAME_SIZE;

	typedef struct packed {
		logic [SAMPLE_W-1:0] value;
		logic [SAMPLE_W-1:0] peak;
		logic                scaled;
	} norm_res_t;

	typedef struct packed {
		logic                act;
		logic [FRAME_W-1:0]  frm;
		logic [INDEX_W-1:0]  idx;
		logic [SAMPLE_W-1:0] smp;
		logic                fixed;
		norm_res_t           res;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [THR_W-1:0]    cfg_wdata;
	logic                in_valid;
	logic                in_ready;
	logic                action;
	logic [FRAME_W-1:0]  frame;
	logic [INDEX_W-1:0]  index;
	logic [SAMPLE_W-1:0] sample;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [SAMPLE_W-1:0] value;
	logic [SAMPLE_W-1:0] peak;
	logic                scaled;

	frame_peak_normalizer_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.frame     (frame),
		.index     (index),
		.sample    (sample),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value),
		.peak      (peak),
		.scaled    (scaled)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// bench copy of the block state
	logic [SAMPLE_W-1:0] wave_mem [MEM_DEPTH];
	logic [SAMPLE_W-1:0] frame_pk [DEF_NUM_FRAMES];
	logic [THR_W-1:0]    silence_thr;
	bit                  written [MEM_DEPTH];
	int unsigned         written_q [$];
	norm_res_t           pending_q [$];

	int err_cnt = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	bit pace_on = 1'b1;

	stim_row_t dir_tab [DIR_ROWS] = '{
		'{ACT_LOAD, 4'd0,  11'd0,    24'h100000, 1'b0, '0},
		'{ACT_READ, 4'd0,  11'd0,    24'h000000, 1'b1, '{24'h100000, 24'h100000, 1'b1}},
		'{ACT_LOAD, 4'd0,  11'd5,    24'hF80000, 1'b0, '0},
		'{ACT_READ, 4'd0,  11'd5,    24'h000000, 1'b1, '{24'hF80000, 24'h100000, 1'b1}},
		'{ACT_LOAD, 4'd1,  11'd0,    24'h800000, 1'b0, '0},
		'{ACT_READ, 4'd1,  11'd0,    24'h000000, 1'b1, '{24'hF00000, 24'h800000, 1'b1}},
		'{ACT_LOAD, 4'd1,  11'd2047, 24'h7FFFFF, 1'b0, '0},
		'{ACT_READ, 4'd1,  11'd2047, 24'h000000, 1'b1, '{24'h0FFFFF, 24'h800000, 1'b1}},
		'{ACT_LOAD, 4'd2,  11'd0,    24'h000000, 1'b0, '0},
		'{ACT_READ, 4'd2,  11'd0,    24'hFFFFFF, 1'b1, '{24'h000000, 24'h000000, 1'b0}},
		'{ACT_LOAD, 4'd15, 11'd10,   24'h7FFFFF, 1'b0, '0},
		'{ACT_LOAD, 4'd15, 11'd11,   24'h800000, 1'b0, '0},
		'{ACT_LOAD, 4'd15, 11'd0,    24'h000010, 1'b0, '0},
		'{ACT_READ, 4'd15, 11'd10,   24'h000000, 1'b1, '{24'h7FFFFF, 24'h000010, 1'b1}},
		'{ACT_READ, 4'd15, 11'd11,   24'h000000, 1'b1, '{24'h800000, 24'h000010, 1'b1}},
		'{ACT_READ, 4'd15, 11'd0,    24'h000000, 1'b1, '{24'h100000, 24'h000010, 1'b1}},
		'{ACT_LOAD, 4'd3,  11'd7,    24'h123456, 1'b0, '0},
		'{ACT_READ, 4'd3,  11'd7,    24'h000000, 1'b1, '{24'h100000, 24'h123456, 1'b1}},
		'{ACT_LOAD, 4'd3,  11'd1024, 24'hEDCBAA, 1'b0, '0},
		'{ACT_READ, 4'd3,  11'd1024, 24'h000000, 1'b1, '{24'hF00000, 24'h123456, 1'b1}},
		'{ACT_LOAD, 4'd10, 11'd1365, 24'h555555, 1'b0, '0},
		'{ACT_LOAD, 4'd10, 11'd682,  24'h2AAAAA, 1'b0, '0},
		'{ACT_READ, 4'd10, 11'd682,  24'hABCDEF, 1'b0, '0}
	};

	function automatic logic [SAMPLE_W-1:0] magnitude(input logic [SAMPLE_W-1:0] s);
		return s[SAMPLE_W-1] ? (~s + 1'b1) : s;
	endfunction

	function automatic norm_res_t normalize(input logic [SAMPLE_W-1:0] raw,
			input logic [SAMPLE_W-1:0] pk);
		norm_res_t   r;
		logic [47:0] num;
		logic [47:0] q;
		r.peak = pk;
		if (pk > {1'b0, silence_thr}) begin
			num = {4'b0, magnitude(raw), 20'b0};
			q = num / {24'b0, pk};
			r.scaled = 1'b1;
			if (raw[SAMPLE_W-1]) begin
				if (q > 48'h800000)
					q = 48'h800000;
				r.value = ~q[SAMPLE_W-1:0] + 1'b1;
			end else begin
				if (q > 48'h7FFFFF)
					q = 48'h7FFFFF;
				r.value = q[SAMPLE_W-1:0];
			end
		end else begin
			r.scaled = 1'b0;
			r.value = raw;
		end
		return r;
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		logic signed [SAMPLE_W-1:0] s;
		s = SAMPLE_W'($urandom);
		case ($urandom_range(0, 9))
			0: s = 24'h800000;
			1: s = 24'h7FFFFF;
			2: s = 24'h000000;
			default: s = s >>> $urandom_range(0, 23);
		endcase
		return s;
	endfunction

	task automatic offer_item(input logic act, input logic [FRAME_W-1:0] frm,
			input logic [INDEX_W-1:0] idx, input logic [SAMPLE_W-1:0] smp,
			input logic fixed, input norm_res_t res);
		int unsigned         addr;
		logic [SAMPLE_W-1:0] m;
		in_valid <= 1'b1;
		action   <= act;
		frame    <= frm;
		index    <= idx;
		sample   <= smp;
		do @(posedge clk); while (!in_ready);
		addr = 32'({frm, idx});
		if (act == ACT_LOAD) begin
			m = magnitude(smp);
			wave_mem[addr] = smp;
			if (!written[addr]) begin
				written[addr] = 1'b1;
				written_q.push_back(addr);
			end
			if (idx == 0 || m > frame_pk[frm])
				frame_pk[frm] = m;
		end else begin
			pending_q.push_back(fixed ? res : normalize(wave_mem[addr], frame_pk[frm]));
		end
	endtask

	task automatic pace_sender();
		if (!pace_on)
			return;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 24);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// receiver: changing stall patterns, one long hold-off mid-run
	int rcv_beats = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int rdy_mode = 0;
	int mode_left = 0;

	always @(posedge clk) begin
		if (out_valid && out_ready)
			rcv_beats++;
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (!hold_done && rcv_beats >= 300) begin
			hold_done = 1'b1;
			hold_left = 400;
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rdy_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			case (rdy_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		norm_res_t want;
		if (out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected beat value=%h peak=%h scaled=%b",
					$time, value, peak, scaled);
				err_cnt++;
			end else begin
				want = pending_q.pop_front();
				if (value !== want.value) begin
					$display("%0t: value exp %h got %h", $time, want.value, value);
					err_cnt++;
				end
				if (peak !== want.peak) begin
					$display("%0t: peak exp %h got %h", $time, want.peak, peak);
					err_cnt++;
				end
				if (scaled !== want.scaled) begin
					$display("%0t: scaled exp %b got %b", $time, want.scaled, scaled);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: watchdog, no beat for %0d cycles", $time, idle_cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int          ph;
		int          n;
		int          kind;
		int unsigned addr;
		logic [THR_W-1:0] thr;

		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		action    = ACT_LOAD;
		frame     = '0;
		index     = '0;
		sample    = '0;
		silence_thr = '0;
		foreach (frame_pk[i])
			frame_pk[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			offer_item(dir_tab[i].act, dir_tab[i].frm, dir_tab[i].idx, dir_tab[i].smp,
				dir_tab[i].fixed, dir_tab[i].res);
			pace_sender();
		end

		for (ph = 0; ph < PHASES; ph++) begin
			drain_results();
			case (ph)
				0: thr = 23'h7FFFFF;
				1: thr = 23'h000000;
				2: thr = THR_W'($urandom);
				3: thr = 23'h400000;
				4: thr = THR_W'($urandom_range(0, 4095));
				default: thr = THR_W'($urandom_range(23'h080000, 23'h200000));
			endcase
			cfg_wdata <= thr;
			cfg_we <= 1'b1;
			@(posedge clk);
			cfg_we <= 1'b0;
			silence_thr = thr;
			pace_on = (ph != 3);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				kind = $urandom_range(0, 99);
				if (kind < 45) begin
					addr = written_q[$urandom_range(0, written_q.size() - 1)];
					offer_item(ACT_READ, addr[14:11], addr[10:0], SAMPLE_W'($urandom),
						1'b0, '0);
				end else if (kind < 57) begin
					offer_item(ACT_LOAD, FRAME_W'($urandom_range(0, 15)), '0,
						pick_sample(), 1'b0, '0);
				end else begin
					offer_item(ACT_LOAD, FRAME_W'($urandom_range(0, 15)),
						INDEX_W'($urandom_range(0, 2047)), pick_sample(), 1'b0, '0);
				end
				pace_sender();
			end
		end

		drain_results();
		if (err_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ filelist.f @@
design/fpn_pkg.sv
design/fpn_store.sv
design/fpn_div.sv
design/frame_peak_normalizer_core.sv
design/fpn_checker.sv
verif/frame_peak_normalizer_core_tb.sv
